### src/slufs_pkg.sv
// ----------------------------------------------------------------------------
// slufs_pkg
// Shared types and constants of the start/length UART frame splitter.
// ----------------------------------------------------------------------------
package slufs_pkg;

    localparam int BUFFER_DEPTH = 64;
    // ring of at least two packets, power of two so pointers wrap for free
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH) + 1;
    localparam int STORE_DEPTH  = 2 ** ADDR_W;
    localparam int PTR_W        = ADDR_W + 1;
    localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
    localparam int LEN_W        = 9;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QIDX_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_MIN_LENGTH = 1'b1;

    localparam logic [7:0] START_BYTE_RESET = 8'hAA;
    localparam logic [7:0] MIN_LENGTH_RESET = 8'd10;

    typedef enum logic [2:0] {
        RSN_PREFIX     = 3'd0,
        RSN_RAW_FULL   = 3'd1,
        RSN_FRAME_FULL = 3'd2,
        RSN_BAD_LENGTH = 3'd3,
        RSN_COMPLETE   = 3'd4,
        RSN_RAW_FLUSH  = 3'd5
    } t_reason;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_packet;
        t_reason    reason;
    } t_out;

    // one packet to drain: start address in the ring, byte count, reason
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [FILL_W-1:0] len;
        t_reason           reason;
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SHOW
    } t_back_state;

endpackage

### src/start_length_uart_frame_splitter_core.sv
// ----------------------------------------------------------------------------
// start_length_uart_frame_splitter_core
// Cuts a received UART byte stream into start-byte/length-field packets.
//
//   channel   direction  handshake                 payload
//   input     in         i_valid / o_ready         i_data  (t_in)
//   output    out        o_valid / i_ready         o_data  (t_out)
//   config    in         i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// An input word is taken on the i_valid/o_ready handshake; the front classifies
// it and writes its byte into a ring of two packet buffers. Each output byte
// passes through the back as a ring memory read, then is shown on the output
// until i_ready takes it; each packet first pops its command from the queue.
// Input stalls only while the command queue (four packets) or the ring is
// full. Synchronous reset clears control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module start_length_uart_frame_splitter_core import slufs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in        i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out       o_data,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_wr              w_wr;
    logic             w_push;
    t_cmd             w_push_cmd;
    logic             w_q_full;
    logic             w_q_empty;
    logic             w_pop;
    t_cmd             w_head_cmd;
    logic [PTR_W-1:0] w_rd_ptr;

    slufs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_q_full),
        .i_rd_ptr    (w_rd_ptr),
        .o_wr        (w_wr),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    slufs_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_cmd   (w_head_cmd)
    );

    slufs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_q_empty (w_q_empty),
        .i_cmd     (w_head_cmd),
        .o_pop     (w_pop),
        .o_rd_ptr  (w_rd_ptr),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

### src/slufs_front.sv
// ----------------------------------------------------------------------------
// slufs_front
// Accepts words, tracks raw/frame collection, writes bytes into the ring and
// queues one drain command for each packet that closes.
// ----------------------------------------------------------------------------
module slufs_front import slufs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in              i_data,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_q_full,
    input  logic [PTR_W-1:0] i_rd_ptr,
    output t_wr              o_wr,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic [7:0]        r_start, n_start;
    logic [7:0]        r_min, n_min;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [LEN_W-1:0]  r_exp, n_exp;
    logic              r_in_frame, n_in_frame;
    logic [PTR_W-1:0]  r_base, n_base;
    logic [PTR_W-1:0]  r_wp, n_wp;

    logic [PTR_W-1:0]  w_used;
    logic              w_accept;
    logic [FILL_W-1:0] w_fill_inc;
    logic [LEN_W-1:0]  w_fill_inc_ext;
    logic [LEN_W-1:0]  w_len_exp;
    logic [7:0]        w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= START_BYTE_RESET;
            r_min      <= MIN_LENGTH_RESET;
            r_fill     <= '0;
            r_exp      <= '0;
            r_in_frame <= 1'b0;
            r_base     <= '0;
            r_wp       <= '0;
        end else begin
            r_start    <= n_start;
            r_min      <= n_min;
            r_fill     <= n_fill;
            r_exp      <= n_exp;
            r_in_frame <= n_in_frame;
            r_base     <= n_base;
            r_wp       <= n_wp;
        end
    end

    // hold off while the ring has no free slot or the queue is full
    assign w_used   = r_wp - i_rd_ptr;
    assign o_ready  = !i_q_full && !w_used[PTR_W-1];
    assign w_accept = i_valid && o_ready;

    assign w_b            = i_data.data_byte;
    assign w_fill_inc     = r_fill + FILL_W'(1);
    assign w_fill_inc_ext = LEN_W'(w_fill_inc);
    assign w_len_exp      = LEN_W'(w_b) + LEN_W'(1);

    always_comb begin
        n_start    = r_start;
        n_min      = r_min;
        n_fill     = r_fill;
        n_exp      = r_exp;
        n_in_frame = r_in_frame;
        n_base     = r_base;
        n_wp       = r_wp;
        o_wr.en    = 1'b0;
        o_wr.addr  = r_wp[ADDR_W-1:0];
        o_wr.data  = w_b;
        o_push     = 1'b0;
        o_cmd.base = r_base[ADDR_W-1:0];
        o_cmd.len  = r_fill;
        o_cmd.reason = RSN_RAW_FLUSH;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_START_BYTE: n_start = i_cfg_data;
                REG_MIN_LENGTH: n_min   = i_cfg_data;
            endcase
        end

        if (w_accept) begin
            if (i_data.command == CMD_FLUSH) begin
                if (!r_in_frame && r_fill != '0) begin
                    o_push = 1'b1;
                    n_base = r_wp;
                    n_fill = '0;
                    n_exp  = '0;
                end
            end else if (!r_in_frame || r_fill == FILL_W'(BUFFER_DEPTH)) begin
                // full frame is sent first, then the word starts a new frame or raw collection
                if (r_in_frame) begin
                    o_push       = 1'b1;
                    o_cmd.reason = RSN_FRAME_FULL;
                end else if (w_b == r_start && r_fill != '0) begin
                    o_push       = 1'b1;
                    o_cmd.reason = RSN_PREFIX;
                end
                o_wr.en = 1'b1;
                n_wp    = r_wp + PTR_W'(1);
                n_exp   = '0;
                if (w_b == r_start) begin
                    n_base     = r_wp;
                    n_fill     = FILL_W'(1);
                    n_in_frame = 1'b1;
                end else if (r_in_frame) begin
                    n_base     = r_wp;
                    n_fill     = FILL_W'(1);
                    n_in_frame = 1'b0;
                end else if (w_fill_inc == FILL_W'(BUFFER_DEPTH)) begin
                    o_push       = 1'b1;
                    o_cmd.len    = w_fill_inc;
                    o_cmd.reason = RSN_RAW_FULL;
                    n_base       = r_wp + PTR_W'(1);
                    n_fill       = '0;
                end else begin
                    n_fill = w_fill_inc;
                end
            end else begin
                o_wr.en   = 1'b1;
                n_wp      = r_wp + PTR_W'(1);
                n_fill    = w_fill_inc;
                o_cmd.len = w_fill_inc;
                if (r_fill == FILL_W'(1)) begin
                    // this word is the length byte
                    n_exp = w_len_exp;
                    if (w_b < r_min || w_len_exp > LEN_W'(BUFFER_DEPTH)) begin
                        o_push       = 1'b1;
                        o_cmd.reason = RSN_BAD_LENGTH;
                    end else if (w_fill_inc_ext >= w_len_exp) begin
                        o_push       = 1'b1;
                        o_cmd.reason = RSN_COMPLETE;
                    end
                end else if (r_exp != '0 && w_fill_inc_ext >= r_exp) begin
                    o_push       = 1'b1;
                    o_cmd.reason = RSN_COMPLETE;
                end
                if (o_push) begin
                    n_base     = r_wp + PTR_W'(1);
                    n_fill     = '0;
                    n_exp      = '0;
                    n_in_frame = 1'b0;
                end
            end
        end
    end

endmodule

### src/slufs_cmd_queue.sv
// ----------------------------------------------------------------------------
// slufs_cmd_queue
// Short FIFO of drain commands between the front and the back.
// ----------------------------------------------------------------------------
module slufs_cmd_queue import slufs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd              r_entry [QUEUE_DEPTH];
    logic [QIDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [QIDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [QCNT_W-1:0] r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_idx] <= i_cmd;
        end
    end

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        if (i_push) begin
            n_wr_idx = (r_wr_idx == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_idx + QIDX_W'(1);
        end
        if (i_pop) begin
            n_rd_idx = (r_rd_idx == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_idx + QIDX_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_entry[r_rd_idx];

endmodule

### src/slufs_back.sv
// ----------------------------------------------------------------------------
// slufs_back
// Holds the packet ring and drains queued packets, one byte per output word.
// ----------------------------------------------------------------------------
module slufs_back import slufs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_wr              i_wr,
    input  logic             i_q_empty,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic [PTR_W-1:0] o_rd_ptr,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out             o_data
);

    logic [7:0]        r_mem [STORE_DEPTH];

    t_back_state       r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [FILL_W-1:0] r_remain, n_remain;
    t_reason           r_reason, n_reason;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    t_out              r_out;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read straight into the output word
    always_ff @(posedge i_clk) begin
        if (r_state == BK_READ) begin
            r_out.out_byte       <= r_mem[r_addr];
            r_out.last_of_packet <= (r_remain == FILL_W'(1));
            r_out.reason         <= r_reason;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_rd_ptr <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_remain <= n_remain;
        r_reason <= n_reason;
    end

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_remain = r_remain;
        n_reason = r_reason;
        n_rd_ptr = r_rd_ptr;
        o_pop    = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop    = 1'b1;
                    n_addr   = i_cmd.base;
                    n_remain = i_cmd.len;
                    n_reason = i_cmd.reason;
                    n_state  = BK_READ;
                end
            end
            BK_READ: begin
                n_state = BK_SHOW;
            end
            BK_SHOW: begin
                if (i_ready) begin
                    // free the slot and advance to the next byte
                    n_addr   = r_addr + ADDR_W'(1);
                    n_remain = r_remain - FILL_W'(1);
                    n_rd_ptr = r_rd_ptr + PTR_W'(1);
                    n_state  = (r_remain == FILL_W'(1)) ? BK_IDLE : BK_READ;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_valid  = (r_state == BK_SHOW);
    assign o_data   = r_out;
    assign o_rd_ptr = r_rd_ptr;

endmodule

### tb/tb_start_length_uart_frame_splitter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_start_length_uart_frame_splitter_core
// Self-checking bench for the start/length UART frame splitter. A behavioral
// deframer predicts every forwarded byte, its last mark and its reason code
// from the accepted input words and the register settings. A monitor checks
// each output word in order against the prediction. Both handshakes idle at
// random, and one long output hold-off makes the block stall its input.
// ----------------------------------------------------------------------------
module tb_start_length_uart_frame_splitter_core;
    import slufs_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 600;
    localparam int MAX_PRINTS    = 40;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_in        i_data;
    logic       o_valid;
    logic       i_ready;
    t_out       o_data;
    logic       i_cfg_we;
    logic [0:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    start_length_uart_frame_splitter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // deframer state and register copies
    logic [7:0] pend_store [BUFFER_DEPTH];
    int         pend_fill  = 0;
    int         frame_len  = 0;
    bit         framing    = 1'b0;
    logic [7:0] start_code = START_BYTE_RESET;
    logic [7:0] min_len    = MIN_LENGTH_RESET;

    t_out expected_bytes [$];
    int   mismatches  = 0;
    int   words_sent  = 0;
    bit   tx_steady   = 1'b0;
    bit   rx_steady   = 1'b0;
    int   rx_hold_len = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic void flush_store(t_reason why);
        if (pend_fill == 0) return;
        for (int i = 0; i < pend_fill; i++) begin
            expected_bytes.push_back(t_out'{out_byte: pend_store[i],
                                            last_of_packet: (i == pend_fill - 1),
                                            reason: why});
        end
        pend_fill = 0;
        frame_len = 0;
        framing   = 1'b0;
    endfunction

    function automatic void hold_byte(logic [7:0] b);
        if (pend_fill < BUFFER_DEPTH) begin
            pend_store[pend_fill] = b;
            pend_fill++;
        end
    endfunction

    function automatic void deframe_word(t_in w);
        logic [7:0] b;
        b = w.data_byte;
        if (w.command == CMD_FLUSH) begin
            // ticks inside a frame are dropped
            if (!framing) flush_store(RSN_RAW_FLUSH);
            return;
        end
        if (framing && pend_fill >= BUFFER_DEPTH) flush_store(RSN_FRAME_FULL);
        if (!framing) begin
            if (b == start_code) begin
                flush_store(RSN_PREFIX);
                hold_byte(b);
                framing = 1'b1;
            end else begin
                hold_byte(b);
                if (pend_fill >= BUFFER_DEPTH) flush_store(RSN_RAW_FULL);
            end
            return;
        end
        hold_byte(b);
        if (pend_fill == 2) begin
            frame_len = int'(pend_store[1]) + 1;
            if (pend_store[1] < min_len || frame_len > BUFFER_DEPTH) begin
                flush_store(RSN_BAD_LENGTH);
                return;
            end
        end
        if (frame_len != 0 && pend_fill >= frame_len) flush_store(RSN_COMPLETE);
    endfunction

    task automatic flag_mismatch(string msg);
        if (mismatches < MAX_PRINTS) $display("%0t MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // output monitor
    always @(posedge i_clk) begin
        t_out want;
        if (o_valid === 1'b1 && i_ready === 1'b1) begin
            if (expected_bytes.size() == 0) begin
                flag_mismatch($sformatf("unexpected word byte=%02h", o_data.out_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (o_data.out_byte !== want.out_byte)
                    flag_mismatch($sformatf("out_byte got %02h want %02h",
                                            o_data.out_byte, want.out_byte));
                if (o_data.last_of_packet !== want.last_of_packet)
                    flag_mismatch($sformatf("last_of_packet got %b want %b",
                                            o_data.last_of_packet, want.last_of_packet));
                if (o_data.reason !== want.reason)
                    flag_mismatch($sformatf("reason got %0d want %0d",
                                            o_data.reason, want.reason));
            end
        end
    end

    // output side: random stalls, steady mode, and a counted hold-off
    initial begin
        bit rx_open;
        int rx_left;
        rx_open = 1'b0;
        rx_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                rx_hold_len--;
                i_ready <= 1'b0;
            end else if (rx_steady) begin
                i_ready <= 1'b1;
            end else begin
                if (rx_left == 0) begin
                    rx_open = !rx_open;
                    rx_left = rx_open ? $urandom_range(1, 16) : pick_gap();
                    if (rx_left == 0) begin
                        rx_open = 1'b1;
                        rx_left = $urandom_range(1, 16);
                    end
                end
                i_ready <= rx_open;
                rx_left--;
            end
        end
    end

    // stop the run when nothing moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_ready === 1'b1) ||
                (o_valid === 1'b1 && i_ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_start_length_uart_frame_splitter_core: done, errors");
        $finish;
    end

    task automatic send_word(logic cmd, logic [7:0] b);
        int gap;
        t_in w;
        gap = tx_steady ? 0 : pick_gap();
        w   = t_in'{command: cmd, data_byte: b};
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        deframe_word(w);
        words_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_word(CMD_BYTE, b);
    endtask

    task automatic send_tick();
        send_word(CMD_FLUSH, 8'($urandom));
    endtask

    // header, length, then payload; optional ticks now and then inside the frame
    task automatic send_frame(logic [7:0] len_byte, int payload, bit with_ticks);
        send_byte(start_code);
        send_byte(len_byte);
        repeat (payload) begin
            if (with_ticks && $urandom_range(0, 14) == 0) send_tick();
            send_byte(8'($urandom));
        end
    endtask

    // drop valid, wait for all predicted words, let the front finish
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(logic [7:0] start_val, logic [7:0] min_val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_START_BYTE;
        i_cfg_data  <= start_val;
        @(posedge i_clk);
        start_code = start_val;
        i_cfg_index <= REG_MIN_LENGTH;
        i_cfg_data  <= min_val;
        @(posedge i_clk);
        min_len = min_val;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        send_tick();                        // empty flush
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_tick();                        // raw flush
        send_byte(8'h12);
        send_byte(start_code);              // prefix goes out first
        send_byte(8'd10);
        repeat (4) send_byte(8'($urandom));
        send_tick();                        // ignored inside a frame
        repeat (5) send_byte(8'($urandom));
        send_byte(start_code);
        send_byte(8'd5);                    // below minimum
        send_byte(start_code);
        send_byte(8'd64);                   // one past the buffer
        send_byte(start_code);
        send_byte(8'hFF);
        send_tick();
        settle();
    endtask

    task automatic test_config_extremes();
        write_config(8'h00, 8'd0);
        send_byte(8'h00);
        send_byte(8'h00);                   // zero length: two-byte frame
        send_frame(8'd63, 62, 1'b0);        // largest frame
        send_byte(8'h00);
        send_byte(8'hFF);
        settle();
        write_config(8'hFF, 8'd255);
        send_byte(8'hFF);
        send_byte(8'd63);
        repeat (BUFFER_DEPTH) send_byte(8'($urandom_range(0, 254)));  // raw full
        send_tick();
        settle();
        write_config(8'h5A, 8'd63);
        send_frame(8'd62, 0, 1'b0);
        send_frame(8'd63, 62, 1'b0);
        send_frame(8'd64, 0, 1'b0);
        settle();
    endtask

    task automatic test_backpressure();
        int stop_at;
        write_config(8'hAA, 8'd10);
        stop_at     = words_sent + 100;
        rx_hold_len = HOLD_CYCLES;
        tx_steady   = 1'b1;
        while (words_sent < stop_at) send_frame(8'd18, 17, 1'b0);
        tx_steady = 1'b0;
        settle();
    endtask

    task automatic test_streaming();
        int stop_at;
        stop_at   = words_sent + 30;
        rx_steady = 1'b1;
        tx_steady = 1'b1;
        while (words_sent < stop_at) begin
            send_byte(8'($urandom));
            send_frame(8'($urandom_range(10, 14)), 0, 1'b0);
            repeat (frame_len - 2) send_byte(8'($urandom));
            send_tick();
        end
        rx_steady = 1'b0;
        tx_steady = 1'b0;
        settle();
    endtask

    task automatic run_random_phase(int count);
        int stop_at;
        int pick;
        int len;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
                if (min_len > 8'd63) len = $urandom_range(0, 255);
                else if ($urandom_range(0, 9) == 0) len = $urandom_range(min_len, 63);
                else len = min_len + $urandom_range(0, 12);
                if (len > 63 && min_len <= 8'd63) len = 63;
                // an oversized length is refused at once, so keep its tail short
                send_frame(8'(len),
                           (len > 63) ? $urandom_range(0, 12) : ((len > 0) ? len - 1 : 0),
                           1'b1);
            end else if (pick < 80) begin
                len = $urandom_range(0, 255);
                send_frame(8'(len), $urandom_range(0, 6), 1'b1);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
                send_tick();
            end else if ($urandom_range(0, 1) == 0) begin
                send_tick();
            end else begin
                send_byte(8'($urandom));
            end
        end
        settle();
    endtask

    task automatic test_random();
        write_config(8'($urandom), 8'($urandom_range(0, 8)));
        run_random_phase(12);
        write_config(8'($urandom), 8'($urandom_range(8, 20)));
        run_random_phase(12);
        write_config(START_BYTE_RESET, MIN_LENGTH_RESET);
        run_random_phase(12);
        write_config(8'($urandom), 8'($urandom));
        run_random_phase(12);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_START_BYTE;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_streaming();
        test_random();

        if (mismatches == 0)
            $display("tb_start_length_uart_frame_splitter_core: done, clean");
        else
            $display("tb_start_length_uart_frame_splitter_core: done, errors");
        $finish;
    end

endmodule

### sim.f
src/slufs_pkg.sv
src/slufs_front.sv
src/slufs_cmd_queue.sv
src/slufs_back.sv
src/start_length_uart_frame_splitter_core.sv
tb/tb_start_length_uart_frame_splitter_core.sv
